[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and defaults for the sorted priority queue
// Operation codes, the control bundle passed between neighbouring cells and
// the default sizes of the queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Default sizes, handed to the top level parameters.
	localparam int unsigned DEF_CAPACITY      = 16;
	localparam int unsigned DEF_PRIORITY_BITS = 16;
	localparam int unsigned DEF_PAYLOAD_BITS  = 32;

	// Operation carried by an input item.
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	// Control seen by a neighbouring cell: whether the slot holds an entry and
	// whether the new entry belongs ahead of it.
	typedef struct packed {
		logic valid;
		logic lower;
	} cell_ctl_t;

endpackage

[rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in sorted order
// A row of slot cells holds the entries from the head downward; each item
// shifts the row by at most one place.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one item: op selects insert
// or pop, priority_req and payload describe an inserted entry. Every item
// gives exactly one result on the output channel (out_valid, out_stall):
// the empty flag, head entry, entry count and the two error flags, all as
// they stand after the item. Equal priorities leave in arrival order.
// An item's result is registered into the result buffer when the item is
// accepted. One item per cycle is sustained while the receiver takes
// results, as every cell of the row compares the new priority at once.
// A two-entry result buffer lets one more item be accepted while a result
// waits; in_stall rises when both entries are full and falls in the cycle
// after the receiver takes a result.
// Reset empties the queue and the result buffer at once; slot contents
// are left as they were and are never shown until rewritten.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY      = DEF_CAPACITY,
	parameter int unsigned PRIORITY_BITS = DEF_PRIORITY_BITS,
	parameter int unsigned PAYLOAD_BITS  = DEF_PAYLOAD_BITS,
	localparam int unsigned CNT_BITS     = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic [PRIORITY_BITS-1:0] priority_req,
	input  logic [PAYLOAD_BITS-1:0]  payload,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     queue_empty,
	output logic [PRIORITY_BITS-1:0] head_priority,
	output logic [PAYLOAD_BITS-1:0]  head_payload,
	output logic [CNT_BITS-1:0]      entry_count,
	output logic                     insert_dropped,
	output logic                     pop_on_empty
);

	typedef struct packed {
		logic                     empty;
		logic [PRIORITY_BITS-1:0] prio;
		logic [PAYLOAD_BITS-1:0]  data;
		logic [CNT_BITS-1:0]      count;
		logic                     dropped;
		logic                     pop_empty;
	} result_t;

	cell_ctl_t                cell_ctl  [CAPACITY];
	logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
	logic [PAYLOAD_BITS-1:0]  cell_data [CAPACITY];
	logic [CAPACITY-1:0]      valid_vec;

	logic [CNT_BITS-1:0] count_q;
	logic                accept;
	logic                is_pop;
	logic                full;
	logic                empty;
	logic                step;
	logic [CNT_BITS-1:0] count_nxt;
	result_t             res;

	result_t             buf_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          fill_q;
	logic                take;
	result_t             res_out;

	// Handshake and item decode.
	assign accept = in_valid && !in_stall;
	assign is_pop = (op == OP_POP);
	assign full   = (count_q == CNT_BITS'(CAPACITY));
	assign empty  = (count_q == '0);
	assign step   = accept && (is_pop ? !empty : !full);

	// Row of slot cells, head at index zero.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t                a_ctl, b_ctl;
		logic [PRIORITY_BITS-1:0] a_prio, b_prio;
		logic [PAYLOAD_BITS-1:0]  a_data, b_data;

		if (i == 0) begin : g_top
			assign a_ctl  = '{valid: 1'b1, lower: 1'b0};
			assign a_prio = '0;
			assign a_data = '0;
		end else begin : g_mid_a
			assign a_ctl  = cell_ctl[i-1];
			assign a_prio = cell_prio[i-1];
			assign a_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign b_ctl  = '{valid: 1'b0, lower: 1'b1};
			assign b_prio = '0;
			assign b_data = '0;
		end else begin : g_mid_b
			assign b_ctl  = cell_ctl[i+1];
			assign b_prio = cell_prio[i+1];
			assign b_data = cell_data[i+1];
		end

		spq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.op        (op_t'(op)),
			.new_prio  (priority_req),
			.new_data  (payload),
			.above_ctl (a_ctl),
			.above_prio(a_prio),
			.above_data(a_data),
			.below_ctl (b_ctl),
			.below_prio(b_prio),
			.below_data(b_data),
			.ctl       (cell_ctl[i]),
			.prio      (cell_prio[i]),
			.data      (cell_data[i])
		);

		assign valid_vec[i] = cell_ctl[i].valid;
	end

	// Entry count.
	always_comb begin
		count_nxt = count_q;
		if (step) begin
			count_nxt = is_pop ? (count_q - 1'b1) : (count_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// Result of the item, built from the row as it will stand after the shift.
	always_comb begin
		res           = '0;
		res.empty     = (count_nxt == '0);
		res.count     = count_nxt;
		res.dropped   = !is_pop && full;
		res.pop_empty = is_pop && empty;
		if (is_pop) begin
			if (!empty && cell_ctl[1].valid) begin
				res.prio = cell_prio[1];
				res.data = cell_data[1];
			end
		end else if (!full && cell_ctl[0].lower) begin
			res.prio = priority_req;
			res.data = payload;
		end else if (cell_ctl[0].valid) begin
			res.prio = cell_prio[0];
			res.data = cell_data[0];
		end
	end

	// Two-entry result buffer between the queue and the receiver.
	assign take      = out_valid && !out_stall;
	assign out_valid = (fill_q != 2'd0);
	assign in_stall  = (fill_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, accept} - {1'b0, take};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	assign res_out        = buf_q[rd_ptr_q];
	assign queue_empty    = res_out.empty;
	assign head_priority  = res_out.prio;
	assign head_payload   = res_out.data;
	assign entry_count    = res_out.count;
	assign insert_dropped = res_out.dropped;
	assign pop_on_empty   = res_out.pop_empty;

	// Checks on the cell row and the result buffer.
`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("occupied slots disagree with entry count");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_vec == CAPACITY'((({{(CAPACITY-1){1'b0}}, 1'b1}) << count_q) - 1'b1))
		else $error("occupied slots are not packed at the head");

	a_buffer_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd2 && !take) |=> (fill_q == 2'd2))
		else $error("result buffer lost an item while full");
`endif

endmodule

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted priority queue
// Holds one entry and, on each effective item, keeps it, takes the new entry,
// takes its upper neighbour's entry (insert) or its lower neighbour's (pop).
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int unsigned PRIORITY_BITS = DEF_PRIORITY_BITS,
	parameter int unsigned PAYLOAD_BITS  = DEF_PAYLOAD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  op_t                      op,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic [PAYLOAD_BITS-1:0]  new_data,
	input  cell_ctl_t                above_ctl,
	input  logic [PRIORITY_BITS-1:0] above_prio,
	input  logic [PAYLOAD_BITS-1:0]  above_data,
	input  cell_ctl_t                below_ctl,
	input  logic [PRIORITY_BITS-1:0] below_prio,
	input  logic [PAYLOAD_BITS-1:0]  below_data,
	output cell_ctl_t                ctl,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic [PAYLOAD_BITS-1:0]  data
);

	logic                     valid_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]  data_q;
	logic                     lower;

	// The new entry goes ahead of an empty slot or one of strictly lower priority.
	assign lower = !valid_q || (prio_q < new_prio);

	assign ctl.valid = valid_q;
	assign ctl.lower = lower;
	assign prio      = prio_q;
	assign data      = data_q;

	// Occupancy of the slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			unique case (op)
				OP_INSERT: begin
					if (lower && !above_ctl.lower) begin
						valid_q <= 1'b1;
					end else if (lower) begin
						valid_q <= above_ctl.valid;
					end
				end
				OP_POP: begin
					valid_q <= below_ctl.valid;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	// Entry contents; no reset, only valid slots are ever read.
	always_ff @(posedge clk) begin
		if (step) begin
			unique case (op)
				OP_INSERT: begin
					if (lower && !above_ctl.lower) begin
						prio_q <= new_prio;
						data_q <= new_data;
					end else if (lower) begin
						prio_q <= above_prio;
						data_q <= above_data;
					end
				end
				OP_POP: begin
					prio_q <= below_prio;
					data_q <= below_data;
				end
				default: begin
					prio_q <= prio_q;
					data_q <= data_q;
				end
			endcase
		end
	end

endmodule
